>>> rtl/core/tftp_cls_pkg.sv
// tftp_cls_pkg: shared types and constants of the tftp flow classifier
// no dependencies
`timescale 1ns / 1ps
package tftp_cls_pkg;
   localparam logic [2:0] ST_CONNECT  = 3'd0;
   localparam logic [2:0] ST_TRANSFER = 3'd1;
   localparam logic [2:0] ST_ACK      = 3'd2;
   localparam logic [2:0] ST_DATA     = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;

   localparam logic [1:0] V_INPROCESS = 2'd0;
   localparam logic [1:0] V_SUCCESS   = 2'd1;
   localparam logic [1:0] V_NOTCOMPAT = 2'd2;
   localparam logic [1:0] V_NOMATCH   = 2'd3;

   localparam logic [2:0] HDR_BAD = 3'd0;

   localparam logic [15:0] OP_RRQ   = 16'h0001;
   localparam logic [15:0] OP_WRQ   = 16'h0002;
   localparam logic [15:0] OP_DATA  = 16'h0003;
   localparam logic [15:0] OP_ACK   = 16'h0004;
   localparam logic [15:0] OP_ERROR = 16'h0005;
   localparam logic [15:0] MAX_ERR_CODE = 16'd7;

   // request parse phases
   localparam logic [2:0] RQ_NAME_FIRST = 3'd2;
   localparam logic [2:0] RQ_NAME       = 3'd3;
   localparam logic [2:0] RQ_MODE_FIRST = 3'd4;
   localparam logic [2:0] RQ_MODE       = 3'd5;
   localparam logic [2:0] RQ_DONE       = 3'd6;
   localparam logic [2:0] RQ_REJECT     = 3'd7;

   localparam int unsigned MIN_REQ_LEN = 6;

   localparam logic [2:0] CSR_COUNT_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_MAX_PAYLOAD     = 3'd1;
   localparam logic [2:0] CSR_START_TRANSFER  = 3'd2;

   typedef struct packed {
      logic [7:0]  count_threshold;
      logic [15:0] max_data_payload;
      logic        start_in_transfer;
   } cfg_type;

   function automatic logic [7:0] mode_a_char(input logic [3:0] i);
      case (i[2:0])
         3'd0: mode_a_char = "n";
         3'd1: mode_a_char = "e";
         3'd2: mode_a_char = "t";
         3'd3: mode_a_char = "a";
         3'd4: mode_a_char = "s";
         3'd5: mode_a_char = "c";
         3'd6: mode_a_char = "i";
         default: mode_a_char = "i";
      endcase
   endfunction

   function automatic logic [7:0] mode_b_char(input logic [3:0] i);
      case (i[2:0])
         3'd0: mode_b_char = "o";
         3'd1: mode_b_char = "c";
         3'd2: mode_b_char = "t";
         3'd3: mode_b_char = "e";
         3'd4: mode_b_char = "t";
         default: mode_b_char = "o";
      endcase
   endfunction
endpackage

>>> rtl/core/tftp_flow_classifier_top.sv
// tftp_flow_classifier_top: tftp flow classifier, one payload byte per beat
// depends on tftp_cls_pkg and tftp_cls_csr
//
//  channel | dir | beat content
//  req_    | in  | tdata = data_byte; tuser = last_byte, from_responder, empty_packet, new_flow
//  rsp_    | out | tdata = verdict, spawn_expected, flow_state, block_number
//  csr_    | in  | apb-style writes and reads of three registers
//
// one byte is taken per cycle while req_tready is high; a packet-end beat gives its result
// in the next cycle via the result register. all parse and flow state updates happen on the
// accept edge, so back-to-back beats need no bubbles. a stalled result holds
// req_tready low only while the result register is full and not being taken.
// reset is synchronous and sets connect state; start_in_transfer sets a new flow's start state.
`timescale 1ns / 1ps
module tftp_flow_classifier_top #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [3:0]  req_tuser,   // [0] last_byte [1] from_responder [2] empty_packet [3] new_flow
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] verdict [2] spawn_expected [5:3] flow_state [21:6] block_number
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

   tftp_cls_pkg::cfg_type cfg;

   tftp_cls_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // flow and parse state
   logic [2:0]  fsm_ff, fsm_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic [15:0] blk_ff, blk_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [15:0] op_ff, op_in, sw_ff, sw_in;
   logic [2:0]  ph_ff, ph_in;
   logic        prn_ff, prn_in;
   logic [3:0]  mpos_ff, mpos_in;
   logic [1:0]  mc_ff, mc_in;
   logic [7:0]  prev_ff, prev_in;
   logic        ov_ff;
   logic [23:0] od_ff, od_in;
   logic        emit;

   logic [7:0] b;
   logic last, resp, empty, fresh, acc;
   assign b = req_tdata;
   assign last = req_tuser[0];
   assign resp = req_tuser[1];
   assign empty = req_tuser[2];
   assign fresh = req_tuser[3];
   assign req_tready = !ov_ff || rsp_tready;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;

   always_comb begin
      logic [7:0] f;
      logic [16:0] len, limit;
      logic [2:0] hdr, st;
      logic [15:0] sblk;
      logic [1:0] v, sv;
      logic spawn, dosq;
      fsm_in = fsm_ff; cnt_in = cnt_ff; fin_in = fin_ff; blk_in = blk_ff;
      pos_in = pos_ff; op_in = op_ff; sw_in = sw_ff; ph_in = ph_ff;
      prn_in = prn_ff; mpos_in = mpos_ff; mc_in = mc_ff; prev_in = prev_ff;
      emit = 1'b0; v = tftp_cls_pkg::V_INPROCESS; spawn = 1'b0;
      f = 8'd0; len = 17'd0; limit = 17'd0; hdr = tftp_cls_pkg::HDR_BAD;
      st = 3'd0; sblk = 16'd0; sv = 2'd0; dosq = 1'b0;

      // restart flow on first beat
      if (fresh && pos_ff == '0) begin
         fsm_in = cfg.start_in_transfer ? tftp_cls_pkg::ST_TRANSFER
                                        : tftp_cls_pkg::ST_CONNECT;
         cnt_in = 8'd0; fin_in = 1'b0; blk_in = 16'd0;
      end

      if (!empty) begin
         if (pos_ff == LENGTH_BITS'(1)) op_in = {prev_ff, b};
         else if (pos_ff == LENGTH_BITS'(3)) sw_in = {prev_ff, b};
         // request parser
         f = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
         if (pos_ff < LENGTH_BITS'(2)) ph_in = 3'(pos_ff) + 3'd1;
         else begin
            case (ph_ff)
               tftp_cls_pkg::RQ_NAME_FIRST: begin
                  if (b == 8'd0) ph_in = tftp_cls_pkg::RQ_REJECT;
                  else begin
                     if (b < 8'h20 || b > 8'h7E) prn_in = 1'b0;
                     ph_in = tftp_cls_pkg::RQ_NAME;
                  end
               end
               tftp_cls_pkg::RQ_NAME: begin
                  if (b == 8'd0) ph_in = tftp_cls_pkg::RQ_MODE_FIRST;
                  else if (b < 8'h20 || b > 8'h7E) prn_in = 1'b0;
               end
               tftp_cls_pkg::RQ_MODE_FIRST, tftp_cls_pkg::RQ_MODE: begin
                  if (b != 8'd0) begin
                     if (mpos_ff >= 4'd8 || f != tftp_cls_pkg::mode_a_char(mpos_ff))
                        mc_in[0] = 1'b0;
                     if (mpos_ff >= 4'd5 || f != tftp_cls_pkg::mode_b_char(mpos_ff))
                        mc_in[1] = 1'b0;
                     if (mpos_ff < 4'd15) mpos_in = mpos_ff + 4'd1;
                     ph_in = tftp_cls_pkg::RQ_MODE;
                  end else if (ph_ff == tftp_cls_pkg::RQ_MODE_FIRST)
                     ph_in = tftp_cls_pkg::RQ_REJECT;
                  else begin
                     if (mpos_ff != 4'd8) mc_in[0] = 1'b0;
                     if (mpos_ff != 4'd5) mc_in[1] = 1'b0;
                     ph_in = (mc_in != 2'd0) ? tftp_cls_pkg::RQ_DONE
                                             : tftp_cls_pkg::RQ_REJECT;
                  end
               end
               default: ;
            endcase
         end
         prev_in = b;
         pos_in = (pos_ff < POS_MAX) ? pos_ff + LENGTH_BITS'(1) : POS_MAX;
         len = 17'(pos_in);
         limit = 17'd4 + 17'(cfg.max_data_payload);

         // header check
         if (len >= 17'd4) begin
            case (op_in)
               tftp_cls_pkg::OP_DATA:
                  hdr = (len > limit) ? tftp_cls_pkg::HDR_BAD : tftp_cls_pkg::ST_DATA;
               tftp_cls_pkg::OP_ACK:
                  hdr = (len != 17'd4) ? tftp_cls_pkg::HDR_BAD : tftp_cls_pkg::ST_ACK;
               tftp_cls_pkg::OP_ERROR:
                  hdr = (sw_in > tftp_cls_pkg::MAX_ERR_CODE || len <= 17'd4 || b != 8'd0)
                        ? tftp_cls_pkg::HDR_BAD : tftp_cls_pkg::ST_ERROR;
               default: hdr = tftp_cls_pkg::HDR_BAD;
            endcase
         end

         if (last) begin
            emit = 1'b1;
            st = fsm_in;
            if (st == tftp_cls_pkg::ST_CONNECT && resp) v = tftp_cls_pkg::V_NOMATCH;
            else if ((st == tftp_cls_pkg::ST_TRANSFER || st == tftp_cls_pkg::ST_DATA)
                     && !resp) v = tftp_cls_pkg::V_INPROCESS;
            else begin
               case (st)
                  tftp_cls_pkg::ST_CONNECT: begin
                     if (len < 17'(tftp_cls_pkg::MIN_REQ_LEN) ||
                         (op_in != tftp_cls_pkg::OP_RRQ && op_in != tftp_cls_pkg::OP_WRQ) ||
                         ph_in != tftp_cls_pkg::RQ_DONE || !prn_in || b != 8'd0)
                        v = tftp_cls_pkg::V_NOTCOMPAT;
                     else spawn = 1'b1;
                  end
                  tftp_cls_pkg::ST_TRANSFER: begin
                     if (hdr == tftp_cls_pkg::HDR_BAD) v = tftp_cls_pkg::V_NOMATCH;
                     else if (hdr == tftp_cls_pkg::ST_ACK) begin
                        if (sw_in != 16'd0) begin
                           fsm_in = tftp_cls_pkg::ST_ERROR; v = tftp_cls_pkg::V_NOMATCH;
                        end else begin
                           fin_in = 1'b0; blk_in = 16'd0; fsm_in = tftp_cls_pkg::ST_ACK;
                        end
                     end else if (hdr == tftp_cls_pkg::ST_DATA) begin
                        if (sw_in != 16'd1) begin
                           fsm_in = tftp_cls_pkg::ST_ERROR; v = tftp_cls_pkg::V_NOMATCH;
                        end else begin
                           blk_in = 16'd1; fsm_in = tftp_cls_pkg::ST_DATA;
                        end
                     end
                  end
                  tftp_cls_pkg::ST_ACK: begin
                     if (hdr == tftp_cls_pkg::HDR_BAD)
                        v = resp ? tftp_cls_pkg::V_NOMATCH : tftp_cls_pkg::V_NOTCOMPAT;
                     else if (hdr == tftp_cls_pkg::ST_ERROR)
                        fsm_in = tftp_cls_pkg::ST_TRANSFER;
                     else if (!resp) begin
                        if (hdr != tftp_cls_pkg::ST_DATA) v = tftp_cls_pkg::V_NOTCOMPAT;
                        else if (len < limit) fin_in = 1'b1;
                     end else if (hdr != tftp_cls_pkg::ST_ACK) v = tftp_cls_pkg::V_NOMATCH;
                     else begin
                        dosq = 1'b1; sblk = sw_in;
                     end
                  end
                  tftp_cls_pkg::ST_DATA: begin
                     if (hdr == tftp_cls_pkg::HDR_BAD) v = tftp_cls_pkg::V_NOMATCH;
                     else if (hdr == tftp_cls_pkg::ST_ERROR) begin
                        fsm_in = tftp_cls_pkg::ST_TRANSFER; dosq = 1'b1; sblk = 16'd0;
                     end else if (hdr != tftp_cls_pkg::ST_DATA) v = tftp_cls_pkg::V_NOMATCH;
                     else begin
                        dosq = 1'b1; sblk = sw_in;
                     end
                  end
                  default: v = tftp_cls_pkg::V_NOMATCH;
               endcase
            end

            // block sequence and count
            if (dosq) begin
               sv = tftp_cls_pkg::V_INPROCESS;
               if (sblk == blk_in + 16'd1) blk_in = blk_in + 16'd1;
               else if (sblk != blk_in) sv = tftp_cls_pkg::V_NOMATCH;
               if (sv == tftp_cls_pkg::V_INPROCESS) begin
                  if (cnt_in < 8'd255) cnt_in = cnt_in + 8'd1;
                  if (cnt_in >= cfg.count_threshold) sv = tftp_cls_pkg::V_SUCCESS;
               end
               v = sv;
               if (sv == tftp_cls_pkg::V_INPROCESS) begin
                  if (st == tftp_cls_pkg::ST_ACK && fin_in)
                     fsm_in = tftp_cls_pkg::ST_TRANSFER;
                  if (st == tftp_cls_pkg::ST_DATA && len < limit)
                     fsm_in = tftp_cls_pkg::ST_TRANSFER;
               end
            end
         end
      end else emit = 1'b1;

      od_in = {2'd0, blk_in, fsm_in, spawn, v};

      // clear per-packet parse state at packet end
      if (emit) begin
         pos_in = '0; op_in = 16'd0; sw_in = 16'd0; ph_in = 3'd0; prn_in = 1'b1;
         mpos_in = 4'd0; mc_in = 2'b11; prev_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= tftp_cls_pkg::ST_CONNECT;
         cnt_ff <= 8'd0; fin_ff <= 1'b0; blk_ff <= 16'd0; pos_ff <= '0;
         op_ff <= 16'd0; sw_ff <= 16'd0; ph_ff <= 3'd0; prn_ff <= 1'b1;
         mpos_ff <= 4'd0; mc_ff <= 2'b11; prev_ff <= 8'd0; ov_ff <= 1'b0;
      end else begin
         if (acc) begin
            fsm_ff <= fsm_in; cnt_ff <= cnt_in; fin_ff <= fin_in; blk_ff <= blk_in;
            pos_ff <= pos_in; op_ff <= op_in; sw_ff <= sw_in; ph_ff <= ph_in;
            prn_ff <= prn_in; mpos_ff <= mpos_in; mc_ff <= mc_in; prev_ff <= prev_in;
         end
         if (acc && emit) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (acc && emit) od_ff <= od_in;
   end
endmodule

>>> rtl/core/tftp_cls_csr.sv
// tftp_cls_csr: apb-style configuration registers
// depends on tftp_cls_pkg
`timescale 1ns / 1ps
module tftp_cls_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output tftp_cls_pkg::cfg_type  cfg
);
   tftp_cls_pkg::cfg_type cfg_ff;
   logic [1:0] idx;
   logic       wr;

   assign idx = csr_paddr[3:2];
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_threshold   <= 8'd1;
         cfg_ff.max_data_payload  <= 16'd512;
         cfg_ff.start_in_transfer <= 1'b0;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         if ({1'b0, idx} == tftp_cls_pkg::CSR_COUNT_THRESHOLD)
            cfg_ff.count_threshold <= csr_pwdata[7:0];
         if ({1'b0, idx} == tftp_cls_pkg::CSR_MAX_PAYLOAD)
            cfg_ff.max_data_payload <= csr_pwdata[15:0];
         if ({1'b0, idx} == tftp_cls_pkg::CSR_START_TRANSFER)
            cfg_ff.start_in_transfer <= csr_pwdata[0];
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[1:0] == 2'b00) begin
         case ({1'b0, idx})
            tftp_cls_pkg::CSR_COUNT_THRESHOLD: csr_prdata = {24'd0, cfg_ff.count_threshold};
            tftp_cls_pkg::CSR_MAX_PAYLOAD:     csr_prdata = {16'd0, cfg_ff.max_data_payload};
            tftp_cls_pkg::CSR_START_TRANSFER:  csr_prdata = {31'd0, cfg_ff.start_in_transfer};
            default:                           csr_prdata = 32'd0;
         endcase
      end
   end
endmodule

>>> verif/tftp_flow_classifier_checker.sv
// tftp_flow_classifier_checker: watches the byte and verdict channels of the classifier,
// predicts every verdict beat and compares field by field; depends on tftp_cls_pkg
`timescale 1ns / 1ps
module tftp_flow_classifier_checker
   import tftp_cls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [3:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_verdicts,
   output int          verdicts_seen,
   output int          successes_seen,
   output int          spawns_seen
);
   localparam int unsigned POS_MAX = 65535;

   typedef struct packed {
      logic [15:0] block_number;
      logic [2:0]  flow_state;
      logic        spawn;
      logic [1:0]  verdict;
   } verdict_beat_type;

   verdict_beat_type verdict_queue[$];

   // shadow configuration
   logic [7:0]  threshold;
   logic [15:0] max_payload;
   logic        start_xfer;

   // shadow flow state
   logic [2:0]  flow_st;
   logic [7:0]  accepted;
   logic        final_seen;
   logic [15:0] cur_block;

   // shadow per-packet parse state
   int unsigned pos;
   logic [15:0] opcode;
   logic [15:0] word2;
   logic [2:0]  phase;
   logic        name_ok;
   logic [3:0]  mode_pos;
   logic [1:0]  mode_live;
   logic [7:0]  prev_b;

   function automatic void clear_packet();
      pos = 0; opcode = '0; word2 = '0; phase = '0; name_ok = 1'b1;
      mode_pos = '0; mode_live = 2'b11; prev_b = '0;
   endfunction

   function automatic void restart_flow();
      flow_st = start_xfer ? ST_TRANSFER : ST_CONNECT;
      accepted = '0; final_seen = 1'b0; cur_block = '0;
   endfunction

   function automatic void mode_step(logic [7:0] b);
      logic [7:0] f;
      logic [7:0] na[8];
      logic [7:0] oc[5];
      na = '{"n", "e", "t", "a", "s", "c", "i", "i"};
      oc = '{"o", "c", "t", "e", "t"};
      f = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (mode_pos >= 8 || f != na[mode_pos[2:0]]) mode_live &= 2'b10;
      if (mode_pos >= 5 || f != oc[mode_pos]) mode_live &= 2'b01;
      if (mode_pos < 15) mode_pos++;
   endfunction

   function automatic void request_step(logic [7:0] b);
      logic prt;
      prt = (b >= 8'h20 && b <= 8'h7e);
      case (phase)
         RQ_NAME_FIRST: begin
            if (b == 0) phase = RQ_REJECT;
            else begin
               if (!prt) name_ok = 1'b0;
               phase = RQ_NAME;
            end
         end
         RQ_NAME: begin
            if (b == 0) phase = RQ_MODE_FIRST;
            else if (!prt) name_ok = 1'b0;
         end
         RQ_MODE_FIRST: begin
            if (b == 0) phase = RQ_REJECT;
            else begin
               mode_step(b);
               phase = RQ_MODE;
            end
         end
         RQ_MODE: begin
            if (b != 0) mode_step(b);
            else begin
               if (mode_pos != 8) mode_live &= 2'b10;
               if (mode_pos != 5) mode_live &= 2'b01;
               phase = (mode_live != 0) ? RQ_DONE : RQ_REJECT;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [2:0] header_kind(int unsigned len, logic [7:0] lastb);
      if (len < 4) return HDR_BAD;
      case (opcode)
         OP_DATA:  return (len > 4 + max_payload) ? HDR_BAD : ST_DATA;
         OP_ACK:   return (len != 4) ? HDR_BAD : ST_ACK;
         OP_ERROR: return (word2 > MAX_ERR_CODE || len <= 4 || lastb != 0) ? HDR_BAD : ST_ERROR;
         default:  return HDR_BAD;
      endcase
   endfunction

   function automatic logic [1:0] sequence_count(logic [15:0] blk);
      if (blk == cur_block + 16'd1) cur_block = cur_block + 16'd1;
      else if (blk != cur_block) return V_NOMATCH;
      if (accepted < 255) accepted++;
      return (accepted >= threshold) ? V_SUCCESS : V_INPROCESS;
   endfunction

   // verdict of one finished packet, may move the flow state
   function automatic logic [1:0] judge_packet(logic [7:0] lastb, logic resp, int unsigned len,
                                               output logic spawn);
      logic [2:0]  kind;
      logic [1:0]  v;
      int unsigned lim;
      spawn = 1'b0;
      lim = 4 + max_payload;
      if (flow_st == ST_CONNECT && resp) return V_NOMATCH;
      if ((flow_st == ST_TRANSFER || flow_st == ST_DATA) && !resp) return V_INPROCESS;
      case (flow_st)
         ST_CONNECT: begin
            if (len < MIN_REQ_LEN || (opcode != OP_RRQ && opcode != OP_WRQ) ||
                phase != RQ_DONE || !name_ok || lastb != 0)
               return V_NOTCOMPAT;
            spawn = 1'b1;
            return V_INPROCESS;
         end
         ST_TRANSFER: begin
            kind = header_kind(len, lastb);
            if (kind == HDR_BAD) return V_NOMATCH;
            if (kind == ST_ACK) begin
               if (word2 != 0) begin
                  flow_st = ST_ERROR;
                  return V_NOMATCH;
               end
               final_seen = 1'b0; cur_block = '0; flow_st = ST_ACK;
            end else if (kind == ST_DATA) begin
               if (word2 != 1) begin
                  flow_st = ST_ERROR;
                  return V_NOMATCH;
               end
               cur_block = 16'd1; flow_st = ST_DATA;
            end
            return V_INPROCESS;
         end
         ST_ACK: begin
            kind = header_kind(len, lastb);
            if (kind == HDR_BAD) return resp ? V_NOMATCH : V_NOTCOMPAT;
            if (kind == ST_ERROR) begin
               flow_st = ST_TRANSFER;
               return V_INPROCESS;
            end
            if (!resp) begin
               if (kind != ST_DATA) return V_NOTCOMPAT;
               if (len < lim) final_seen = 1'b1;
               return V_INPROCESS;
            end
            if (kind != ST_ACK) return V_NOMATCH;
            v = sequence_count(word2);
            if (v != V_INPROCESS) return v;
            if (final_seen) flow_st = ST_TRANSFER;
            return V_INPROCESS;
         end
         ST_DATA: begin
            kind = header_kind(len, lastb);
            if (kind == HDR_BAD) return V_NOMATCH;
            if (kind == ST_ERROR) flow_st = ST_TRANSFER;
            else if (kind != ST_DATA) return V_NOMATCH;
            v = sequence_count(kind == ST_ERROR ? 16'd0 : word2);
            if (v != V_INPROCESS) return v;
            if (len < lim) flow_st = ST_TRANSFER;
            return V_INPROCESS;
         end
         default: return V_NOMATCH;
      endcase
   endfunction

   // one accepted byte beat
   function automatic void take_byte(logic [7:0] b, logic [3:0] u);
      verdict_beat_type r;
      logic spawn;
      r = '0;
      spawn = 1'b0;
      if (u[3] && pos == 0) restart_flow();
      if (!u[2]) begin
         if (pos == 1) opcode = {prev_b, b};
         else if (pos == 3) word2 = {prev_b, b};
         if (pos < 2) phase = 3'(pos + 1);
         else request_step(b);
         prev_b = b;
         pos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
         if (!u[0]) return;
         r.verdict = judge_packet(b, u[1], pos, spawn);
      end
      clear_packet();
      r.spawn = spawn;
      r.flow_state = flow_st;
      r.block_number = cur_block;
      verdict_queue.push_back(r);
   endfunction

   always @(posedge clock) begin
      verdict_beat_type got, want;
      if (reset) begin
         threshold = 8'd1; max_payload = 16'd512; start_xfer = 1'b0;
         restart_flow();
         clear_packet();
         verdict_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               CSR_COUNT_THRESHOLD[1:0]: threshold = csr_pwdata[7:0];
               CSR_MAX_PAYLOAD[1:0]:     max_payload = csr_pwdata[15:0];
               CSR_START_TRANSFER[1:0]:  start_xfer = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[21:0];
            verdicts_seen++;
            if (verdict_queue.size() == 0) begin
               $error("verdict beat %h with none expected", rsp_tdata);
               fail_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (got.verdict == V_SUCCESS) successes_seen++;
               if (got.spawn) spawns_seen++;
               if (got.verdict != want.verdict) begin
                  $error("verdict: expected %0d actual %0d", want.verdict, got.verdict);
                  fail_count++;
               end
               if (got.spawn != want.spawn) begin
                  $error("spawn_expected: expected %0d actual %0d", want.spawn, got.spawn);
                  fail_count++;
               end
               if (got.flow_state != want.flow_state) begin
                  $error("flow_state: expected %0d actual %0d", want.flow_state,
                         got.flow_state);
                  fail_count++;
               end
               if (got.block_number != want.block_number) begin
                  $error("block_number: expected %0d actual %0d", want.block_number,
                         got.block_number);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tuser);
      end
      pending_verdicts = verdict_queue.size();
   end
endmodule

>>> verif/tftp_flow_classifier_top_tb.sv
// tftp_flow_classifier_top_tb: drives packets and register writes into the classifier
// and gives the verdict; depends on tftp_cls_pkg, the block and the checker
`timescale 1ns / 1ps
module tftp_flow_classifier_top_tb;
   import tftp_cls_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [3:0]  req_tuser = '0;   // [0] last [1] from_responder [2] empty [3] new_flow
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [1:0] verdict [2] spawn [5:3] flow_state [21:6] block
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending_verdicts, verdicts_seen, successes_seen, spawns_seen;
   int send_idle_pct, recv_stall_pct;
   int hold_off = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int beats_sent;

   typedef logic [7:0] byte_q_type[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tftp_flow_classifier_top dut (.*);

   tftp_flow_classifier_checker checker_i (.*);

   initial begin
      #4000000;
      $display("tftp_flow_classifier_top regression: fail");
      $finish;
   end

   // result side back-pressure, with a long hold-off each time hold_req is bumped
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_off <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx[1:0], 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // one beat, waits for acceptance; idles before it at the current rate
   task automatic send_beat(logic [7:0] b, logic [3:0] u);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1; req_tdata <= b; req_tuser <= u;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_packet(byte_q_type pkt, logic resp, logic fresh);
      if (pkt.size() == 0) begin
         send_beat($urandom, {fresh, 1'b1, resp, 1'b0});
      end else begin
         foreach (pkt[i])
            send_beat(pkt[i], {(i == 0) && fresh, 1'b0, resp, i == pkt.size() - 1});
      end
   endtask

   // stop sending and wait until every expected verdict has come
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic byte_q_type header(logic [15:0] op, logic [15:0] w2);
      byte_q_type q;
      q = '{op[15:8], op[7:0], w2[15:8], w2[7:0]};
      return q;
   endfunction

   function automatic byte_q_type request_pkt(int flavour);
      byte_q_type q;
      string m;
      int n;
      q = '{8'h00, ($urandom_range(1) ? 8'h01 : 8'h02)};
      if (flavour == 1) q[1] = $urandom;
      n = $urandom_range(1, 6);
      if (flavour == 3) n = 0;
      for (int i = 0; i < n; i++)
         q.push_back(flavour == 2 ? $urandom : 8'($urandom_range(8'h20, 8'h7e)));
      q.push_back(8'h00);
      case ($urandom_range(3))
         0: m = "netascii";
         1: m = "OcTeT";
         2: m = "NETASCII";
         default: m = (flavour == 4) ? "octets" : "octet";
      endcase
      for (int i = 0; i < m.len(); i++) q.push_back(m[i]);
      q.push_back(8'h00);
      if ($urandom_range(4) == 0) begin
         q.push_back($urandom); q.push_back(8'h00);
      end
      if (flavour == 5) q[q.size() - 1] = 8'h41;
      return q;
   endfunction

   function automatic byte_q_type data_pkt(logic [15:0] blk, int len);
      byte_q_type q;
      q = header(OP_DATA, blk);
      for (int i = 0; i < len; i++) q.push_back($urandom);
      return q;
   endfunction

   function automatic byte_q_type error_pkt(logic [15:0] code);
      byte_q_type q;
      q = header(OP_ERROR, code);
      q.push_back(8'h41); q.push_back(8'h00);
      return q;
   endfunction

   function automatic byte_q_type noise_pkt();
      byte_q_type q;
      int n;
      n = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) q.push_back($urandom);
      return q;
   endfunction

   // a read or write session: request, then data/ack exchange with random faults
   task automatic run_session(int mp);
      byte_q_type q;
      logic [15:0] blk;
      int rounds;
      logic writes;
      q = request_pkt(($urandom_range(5) == 0) ? $urandom_range(1, 5) : 0);
      send_packet(q, $urandom_range(15) == 0, 1'b1);
      writes = $urandom_range(1);
      if (writes) send_packet(header(OP_ACK, 16'd0), 1'b1, 1'b0);
      blk = 16'd1;
      rounds = $urandom_range(1, 6);
      for (int r = 0; r < rounds; r++) begin
         int len;
         logic [15:0] b;
         len = (r == rounds - 1) ? $urandom_range(0, mp - 1) : mp;
         if (len > 40) len = $urandom_range(0, 6);
         b = ($urandom_range(9) == 0) ? 16'($urandom) : blk;
         case ($urandom_range(11))
            0: send_packet(error_pkt($urandom_range(9)), $urandom_range(1), 1'b0);
            1: send_packet(noise_pkt(), $urandom_range(1), 1'b0);
            2: send_packet(header(OP_ACK, b), 1'b1, 1'b0);
            default: begin
               send_packet(data_pkt(b, len), !writes, 1'b0);
               send_packet(header(OP_ACK, b), writes, 1'b0);
            end
         endcase
         blk++;
      end
   endtask

   task automatic configure(int th, int mp, logic sx);
      drain();
      csr_write(CSR_COUNT_THRESHOLD, th);
      csr_write(CSR_MAX_PAYLOAD, mp);
      csr_write(CSR_START_TRANSFER, sx);
   endtask

   initial begin
      byte_q_type q;
      int mp;
      send_idle_pct = 0; recv_stall_pct = 0; beats_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: valid request, data sequence, empty packet, broken packets
      send_packet(request_pkt(0), 1'b0, 1'b1);
      send_packet('{}, 1'b0, 1'b0);
      send_packet(request_pkt(0), 1'b1, 1'b1);
      send_packet(request_pkt(3), 1'b0, 1'b1);
      send_packet('{8'h00}, 1'b0, 1'b1);
      send_packet('{8'h00, 8'h03, 8'h00}, 1'b1, 1'b1);
      // empty mark inside a packet
      send_beat(8'hff, 4'b1000);
      send_beat(8'h00, 4'b0110);
      configure(3, 4, 1);
      send_packet(data_pkt(1, 4), 1'b1, 1'b1);
      send_packet(data_pkt(2, 4), 1'b0, 1'b0);
      send_packet(error_pkt(7), 1'b1, 1'b0);
      send_packet(header(OP_ACK, 0), 1'b1, 1'b1);
      send_packet(header(OP_ACK, 1), 1'b1, 1'b0);
      send_packet(error_pkt(8), 1'b1, 1'b0);
      send_packet(header(OP_ACK, 16'hffff), 1'b1, 1'b1);
      // long data payload under the widest limit
      configure(255, 65531, 1);
      q = data_pkt(1, 100);
      send_packet(q, 1'b1, 1'b1);
      configure(1, 1, 0);

      // random sessions over idle phases and settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         mp = (ph == 7) ? 65531 : $urandom_range(1, 20);
         configure((ph == 5) ? 255 : $urandom_range(1, 4), mp, ph[0] & ph[1]);
         if (ph == 2) hold_req++;
         if (ph == 4) drain();
         while (beats_sent < (ph + 1) * 1450 / 8)
            if ($urandom_range(9) == 0) send_packet(noise_pkt(), $urandom_range(1), 1'b1);
            else run_session(mp);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d byte beats, %0d verdicts, %0d successes, %0d spawns",
               beats_sent, verdicts_seen, successes_seen, spawns_seen);
      if (fail_count == 0)
         $display("tftp_flow_classifier_top regression: pass");
      else
         $display("tftp_flow_classifier_top regression: fail");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/tftp_cls_pkg.sv
rtl/core/tftp_cls_csr.sv
rtl/core/tftp_flow_classifier_top.sv
verif/tftp_flow_classifier_checker.sv
verif/tftp_flow_classifier_top_tb.sv
